[hw/rtl/tpa_pkg.sv]
`default_nettype none

package tpa_pkg;

	localparam int COORD_W    = 12;
	localparam int PRESSURE_W = 12;
	localparam int WAIT_W     = 17;
	localparam int SUM_W      = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	localparam logic [PRESSURE_W-1:0] TOUCH_THRESHOLD_RST = PRESSURE_W'(25);
	localparam logic [WAIT_W-1:0]     WAIT_MS_RST         = '1;

	localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_MS         = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		EV_TAP_DOWN  = 2'd0,
		EV_TAP_UP    = 2'd1,
		EV_TIMEOUT   = 2'd2,
		EV_NO_POINTS = 2'd3
	} event_t;

endpackage

`default_nettype wire

[hw/rtl/tpa_div.sv]
`default_nettype none

// Restoring divider: one quotient bit per cycle, the dividend shifting out of
// the top of the work register while quotient bits shift in at the bottom.
module tpa_div
	import tpa_pkg::*;
#(
	parameter int DIV_W = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SUM_W-1:0]   dividend,
	input  wire logic [DIV_W-1:0]   divisor,
	output logic                    done,
	output logic [COORD_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  work_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_W:0]    shifted;
	logic [DIV_W:0]    diff;
	logic              ge;

	assign shifted = {rem_q, work_q[SUM_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[SUM_W-2:0], ge};
			rem_q  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	// The average never exceeds a single coordinate, so the low bits suffice.
	assign quotient = work_q[COORD_W-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire

[hw/rtl/touch_press_averager.sv]
// Touch press averager. Each input transfer is one controller sample (pressure,
// x, y). A sample above the touch threshold starts a press; later samples with
// both coordinates nonzero are summed, up to MAX_POINTS of them. A release
// sample produces a tap-down result with the truncated averages followed by a
// tap-up result (tlast on the tap-up), or a single error result if no point
// was taken. Idle samples count down wait_ms and produce a timeout result when
// it runs out; a negative wait_ms never times out. Samples are taken
// whenever the result side has room, but a release with points holds off the
// next sample while two bit-serial dividers work out one quotient bit each per
// step over the 22-bit sums, the quotients are handed over, and the tap-down
// and tap-up results wait in turn for room on the result side. Configuration
// registers are to be written only while the block is idle, by the user; the
// block does not enforce it, only holding off a write while it takes a sample.
`default_nettype none

module touch_press_averager
	import tpa_pkg::*;
#(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // pressure, raw_x, raw_y, zero pad
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // avg_x, avg_y
	output logic [1:0]                 m_tuser,  // event_res
	output logic                       m_tlast
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [1:0] {
		ST_IN,
		ST_DIV,
		ST_TAP,
		ST_UP
	} state_t;

	state_t                  state_q;
	logic [PRESSURE_W-1:0]   touch_threshold_q;
	logic [WAIT_W-1:0]       wait_ms_q;
	logic [WAIT_W-1:0]       wait_left_q;
	logic                    pressed_q;
	logic [SUM_W-1:0]        sum_x_q;
	logic [SUM_W-1:0]        sum_y_q;
	logic [CNT_W-1:0]        count_q;
	logic                    m_tvalid_q;
	event_t                  out_event_q;
	logic [COORD_W-1:0]      out_x_q;
	logic [COORD_W-1:0]      out_y_q;
	logic                    out_last_q;

	logic [PRESSURE_W-1:0]   pressure;
	logic [COORD_W-1:0]      raw_x;
	logic [COORD_W-1:0]      raw_y;
	logic                    out_free;
	logic                    out_load;
	logic                    accept;
	logic                    release_smp;
	logic                    count_full;
	logic                    div_start;
	logic                    div_done;
	logic                    div_done_y;
	logic [COORD_W-1:0]      quot_x;
	logic [COORD_W-1:0]      quot_y;

	assign pressure = s_tdata[PRESSURE_W-1:0];
	assign raw_x    = s_tdata[PRESSURE_W +: COORD_W];
	assign raw_y    = s_tdata[PRESSURE_W+COORD_W +: COORD_W];

	assign out_free    = !m_tvalid_q || m_tready;
	assign s_tready    = (state_q == ST_IN) && out_free;
	assign accept      = s_tvalid && s_tready;
	assign release_smp = pressure <= touch_threshold_q;
	assign count_full  = count_q == CNT_W'(MAX_POINTS);
	assign div_start   = accept && pressed_q && release_smp && (count_q != '0);
	assign cfg_ready   = !accept;

	// A result enters the output register on an error release, on a timeout,
	// and on each of the two tap transfers.
	assign out_load = (accept && pressed_q && release_smp && (count_q == '0))
		|| (accept && !pressed_q && release_smp && (wait_left_q == '0))
		|| (((state_q == ST_TAP) || (state_q == ST_UP)) && out_free);

	tpa_div #(.DIV_W(CNT_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quot_x)
	);

	// Both dividers run in lockstep on the same count.
	tpa_div #(.DIV_W(CNT_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y_q),
		.divisor  (count_q),
		.done     (div_done_y),
		.quotient (quot_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IN;
			touch_threshold_q <= TOUCH_THRESHOLD_RST;
			wait_ms_q         <= WAIT_MS_RST;
			wait_left_q       <= WAIT_MS_RST;
			pressed_q         <= 1'b0;
			sum_x_q           <= '0;
			sum_y_q           <= '0;
			count_q           <= '0;
			m_tvalid_q        <= 1'b0;
			out_event_q       <= EV_TAP_DOWN;
			out_x_q           <= '0;
			out_y_q           <= '0;
			out_last_q        <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IN: begin
					if (accept) begin
						if (pressed_q) begin
							if (release_smp) begin
								pressed_q   <= 1'b0;
								wait_left_q <= wait_ms_q;
								if (count_q == '0) begin
									out_event_q <= EV_NO_POINTS;
									out_x_q     <= '0;
									out_y_q     <= '0;
									out_last_q  <= 1'b1;
								end else begin
									state_q <= ST_DIV;
								end
							end else if (raw_x != '0 && raw_y != '0 && !count_full) begin
								sum_x_q <= sum_x_q + SUM_W'(raw_x);
								sum_y_q <= sum_y_q + SUM_W'(raw_y);
								count_q <= count_q + CNT_W'(1);
							end
						end else if (!release_smp) begin
							pressed_q <= 1'b1;
							sum_x_q   <= '0;
							sum_y_q   <= '0;
							count_q   <= '0;
						end else if (!wait_left_q[WAIT_W-1]) begin
							if (wait_left_q == '0) begin
								wait_left_q <= wait_ms_q;
								out_event_q <= EV_TIMEOUT;
								out_x_q     <= '0;
								out_y_q     <= '0;
								out_last_q  <= 1'b1;
							end else begin
								wait_left_q <= wait_left_q - WAIT_W'(1);
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done && div_done_y) begin
						state_q <= ST_TAP;
					end
				end
				ST_TAP: begin
					if (out_free) begin
						out_event_q <= EV_TAP_DOWN;
						out_x_q     <= quot_x;
						out_y_q     <= quot_y;
						out_last_q  <= 1'b0;
						state_q     <= ST_UP;
					end
				end
				ST_UP: begin
					if (out_free) begin
						out_event_q <= EV_TAP_UP;
						out_x_q     <= '0;
						out_y_q     <= '0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IN;
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOUCH_THRESHOLD: begin
						touch_threshold_q <= cfg_data[PRESSURE_W-1:0];
					end
					REG_WAIT_MS: begin
						wait_ms_q   <= cfg_data[WAIT_W-1:0];
						wait_left_q <= cfg_data[WAIT_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tuser  = out_event_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
